// ===== rtl/apqm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apqm_pkg
// Types, register indexes and helpers shared by the attitude PID / quad mixer.
// ----------------------------------------------------------------------------
package apqm_pkg;

   localparam int AXES         = 3;
   localparam int AXIS_YAW     = 0;
   localparam int AXIS_PITCH   = 1;
   localparam int AXIS_ROLL    = 2;

   // registered stages in one axis lane, input beat to clamped correction
   localparam int LANE_LATENCY = 6;

   localparam int IDLE_OFFSET  = 10;

   // configuration register indexes
   localparam logic [2:0] CSR_GAINS_YAW       = 3'd0;
   localparam logic [2:0] CSR_GAINS_PITCH     = 3'd1;
   localparam logic [2:0] CSR_GAINS_ROLL      = 3'd2;
   localparam logic [2:0] CSR_PID_LIMIT       = 3'd3;
   localparam logic [2:0] CSR_THROTTLE_CUTOFF = 3'd4;
   localparam logic [2:0] CSR_MOTOR_LOW       = 3'd5;
   localparam logic [2:0] CSR_MOTOR_HIGH      = 3'd6;

   // Q0.16 gains, packed as in the register: P lowest, D highest
   typedef struct packed {
      logic [15:0] kd;
      logic [15:0] ki;
      logic [15:0] kp;
   } gains_type;

   typedef struct packed {
      logic [15:0] motor_low;
      logic [15:0] motor_high;
      logic [15:0] throttle_cutoff;
   } mix_cfg_type;

   // one result beat, last field in the lowest bits
   typedef struct packed {
      logic signed [15:0] corr_roll;
      logic signed [15:0] corr_pitch;
      logic signed [15:0] corr_yaw;
      logic [15:0]        motor_rear_b;
      logic [15:0]        motor_rear_a;
      logic [15:0]        motor_front_b;
      logic [15:0]        motor_front_a;
   } result_type;

   localparam gains_type   GAINS_YAW_RESET   = gains_type'(48'd0);
   localparam gains_type   GAINS_AXIS_RESET  = gains_type'(48'd3840);
   localparam logic [14:0] PID_LIMIT_RESET   = 15'd400;
   localparam logic [15:0] CUTOFF_RESET      = 16'd100;
   localparam logic [15:0] MOTOR_LOW_RESET   = 16'd1024;
   localparam logic [15:0] MOTOR_HIGH_RESET  = 16'd2048;

   // high limit is checked first; when the limits cross, values above it get high, all others low
   function automatic logic [15:0] clamp_motor(logic signed [18:0] v,
                                               logic [15:0] lo,
                                               logic [15:0] hi);
      logic signed [18:0] lo_s;
      logic signed [18:0] hi_s;
      lo_s = $signed({3'b000, lo});
      hi_s = $signed({3'b000, hi});
      if (v > hi_s) begin
         return hi;
      end else if (v < lo_s) begin
         return lo;
      end else begin
         return v[15:0];
      end
   endfunction

endpackage

// ===== rtl/apqm_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apqm_lane
// One axis: error, P/I/D products, saturating integral, truncate and clamp.
// ----------------------------------------------------------------------------
module apqm_lane #(
   parameter int INTEGRAL_WIDTH = 48
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic signed [15:0]      set_angle,
   input  logic signed [15:0]      meas_angle,
   input  apqm_pkg::gains_type     gains,
   input  logic [14:0]             pid_limit,
   output logic signed [15:0]      corr
);

   localparam int IW = INTEGRAL_WIDTH;
   localparam logic signed [IW-1:0] INT_MAX = {1'b0, {(IW-1){1'b1}}};
   localparam logic signed [IW-1:0] INT_MIN = {1'b1, {(IW-1){1'b0}}};
   localparam logic signed [63:0]   SUM_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0]   SUM_MIN = {1'b1, {63{1'b0}}};

   // stage 1: error and error step
   logic signed [16:0]    err_in, err_ff;
   logic signed [17:0]    diff_in, diff_ff;
   logic signed [16:0]    last_err_ff;
   logic                  v1_ff;
   // stage 2: products (Q16.16)
   logic signed [33:0]    p_in, p_ff;
   logic signed [33:0]    ie_in, ie_ff;
   logic signed [34:0]    d_in, d_ff;
   logic                  v2_ff;
   // stage 3: integral and P+D
   logic signed [IW:0]    isum;
   logic signed [IW-1:0]  integral_in, integral_ff;
   logic signed [35:0]    pd_in, pd_ff;
   // stage 4: saturated axis sum
   logic signed [65:0]    wide_sum;
   logic signed [63:0]    sum_in, sum_ff;
   // stage 5: whole units, toward zero
   logic signed [64:0]    biased;
   logic signed [48:0]    whole_in, whole_ff;
   // stage 6: clamp
   logic signed [48:0]    lim, neg_lim;
   logic signed [15:0]    corr_in, corr_ff;

   assign err_in  = 17'(set_angle) - 17'(meas_angle);
   assign diff_in = 18'(err_in) - 18'(last_err_ff);

   assign p_in  = 34'(err_ff) * 34'($signed({1'b0, gains.kp}));
   assign ie_in = 34'(err_ff) * 34'($signed({1'b0, gains.ki}));
   assign d_in  = 35'(diff_ff) * 35'($signed({1'b0, gains.kd}));

   assign isum  = (IW+1)'(integral_ff) + (IW+1)'(ie_ff);
   assign pd_in = 36'(p_ff) + 36'(d_ff);

   always_comb begin
      if (isum[IW] != isum[IW-1]) begin
         integral_in = isum[IW] ? INT_MIN : INT_MAX;
      end else begin
         integral_in = isum[IW-1:0];
      end
   end

   // integral_ff already holds this beat's value when it reaches stage 4
   assign wide_sum = 66'(pd_ff) + 66'(integral_ff);

   always_comb begin
      if (wide_sum[65:63] == 3'b000 || wide_sum[65:63] == 3'b111) begin
         sum_in = wide_sum[63:0];
      end else begin
         sum_in = wide_sum[65] ? SUM_MIN : SUM_MAX;
      end
   end

   assign biased   = 65'(sum_ff) + (sum_ff[63] ? 65'sd65535 : 65'sd0);
   assign whole_in = biased[64:16];

   assign lim     = $signed({34'd0, pid_limit});
   assign neg_lim = -lim;

   always_comb begin
      if (whole_ff > lim) begin
         corr_in = lim[15:0];
      end else if (whole_ff < neg_lim) begin
         corr_in = neg_lim[15:0];
      end else begin
         corr_in = whole_ff[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff       <= 1'b0;
         v2_ff       <= 1'b0;
         last_err_ff <= '0;
         integral_ff <= '0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         if (in_valid) begin
            last_err_ff <= err_in;
         end
         if (v2_ff) begin
            integral_ff <= integral_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      err_ff   <= err_in;
      diff_ff  <= diff_in;
      p_ff     <= p_in;
      ie_ff    <= ie_in;
      d_ff     <= d_in;
      pd_ff    <= pd_in;
      sum_ff   <= sum_in;
      whole_ff <= whole_in;
      corr_ff  <= corr_in;
   end

   assign corr = corr_ff;

endmodule

// ===== rtl/apqm_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apqm_mixer
// Merges the three axis corrections into four X-quad motor commands.
// ----------------------------------------------------------------------------
module apqm_mixer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [15:0]           throttle,
   input  logic signed [15:0]    corr_yaw,
   input  logic signed [15:0]    corr_pitch,
   input  logic signed [15:0]    corr_roll,
   input  apqm_pkg::mix_cfg_type cfg,
   output logic                  out_valid,
   output apqm_pkg::result_type  result
);

   logic signed [18:0]   base, cy, cp, cr, idle;
   logic signed [18:0]   sum_fa, sum_fb, sum_ra, sum_rb;
   logic [15:0]          idle_cmd;
   logic                 cut;
   logic                 valid_ff;
   apqm_pkg::result_type result_in, result_ff;

   assign base = $signed({3'b000, cfg.motor_low}) + $signed({3'b000, throttle});
   assign idle = $signed({3'b000, cfg.motor_low}) + 19'(apqm_pkg::IDLE_OFFSET);
   assign cy   = 19'(corr_yaw);
   assign cp   = 19'(corr_pitch);
   assign cr   = 19'(corr_roll);

   assign sum_fa = base + cp + cr - cy;
   assign sum_fb = base + cp - cr + cy;
   assign sum_ra = base - cp - cr - cy;
   assign sum_rb = base - cp + cr + cy;

   assign cut      = throttle < cfg.throttle_cutoff;
   assign idle_cmd = apqm_pkg::clamp_motor(idle, cfg.motor_low, cfg.motor_high);

   always_comb begin
      result_in.corr_yaw   = corr_yaw;
      result_in.corr_pitch = corr_pitch;
      result_in.corr_roll  = corr_roll;
      if (cut) begin
         result_in.motor_front_a = idle_cmd;
         result_in.motor_front_b = idle_cmd;
         result_in.motor_rear_a  = idle_cmd;
         result_in.motor_rear_b  = idle_cmd;
      end else begin
         result_in.motor_front_a = apqm_pkg::clamp_motor(sum_fa, cfg.motor_low,
                                                         cfg.motor_high);
         result_in.motor_front_b = apqm_pkg::clamp_motor(sum_fb, cfg.motor_low,
                                                         cfg.motor_high);
         result_in.motor_rear_a  = apqm_pkg::clamp_motor(sum_ra, cfg.motor_low,
                                                         cfg.motor_high);
         result_in.motor_rear_b  = apqm_pkg::clamp_motor(sum_rb, cfg.motor_low,
                                                         cfg.motor_high);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign out_valid = valid_ff;
   assign result    = result_ff;

endmodule

// ===== rtl/apqm_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apqm_fifo
// Result queue between the pipeline and the rsp_ channel.
// ----------------------------------------------------------------------------
module apqm_fifo #(
   parameter int DEPTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  apqm_pkg::result_type wr_data,
   output logic                 rd_valid,
   input  logic                 rd_ready,
   output apqm_pkg::result_type rd_data
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   apqm_pkg::result_type mem_ff [DEPTH];
   logic [PW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 rd_fire;

   assign rd_valid = count_ff != '0;
   assign rd_fire  = rd_valid && rd_ready;
   assign rd_data  = mem_ff[rd_ptr_ff];

   assign wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_fire) begin
         count_in = count_ff + 1'b1;
      end else if (!wr_en && rd_fire) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_in;
         end
         if (rd_fire) begin
            rd_ptr_ff <= rd_ptr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== rtl/attitude_pid_quad_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// attitude_pid_quad_mixer
// Three-axis attitude PID (one lane per axis) feeding an X-quad motor mixer.
// ----------------------------------------------------------------------------
//  channel  dir  beat / fields (lowest bits first)
//  req_     in   set_yaw, set_pitch, set_roll, meas_yaw, meas_pitch,
//                meas_roll, throttle (16 bits each)
//  rsp_     out  motor_front_a, motor_front_b, motor_rear_a, motor_rear_b,
//                corr_yaw, corr_pitch, corr_roll (16 bits each)
//  csr_     in   write enable, register index, 48-bit data
//
// One beat per cycle while req_tready is high; the path from a req_ beat to its
// rsp_ beat runs through six lane stages, the mixer register and the result
// queue. A credit comes back when its rsp_ beat is taken.
// req_tready drops once RESULT_DEPTH results are in flight or queued, so
// a stalled rsp_ side never loses a beat; the pipeline itself never stalls.
// Synchronous reset clears integrals, last errors and registers to defaults.
// ----------------------------------------------------------------------------
module attitude_pid_quad_mixer #(
   parameter int INTEGRAL_WIDTH = 48,  // 33..64
   parameter int RESULT_DEPTH   = 16   // 2..32, 9 or more for full rate
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // set_yaw, set_pitch, set_roll, meas_yaw, meas_pitch, meas_roll, throttle
   input  logic [111:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // motor_front_a, motor_front_b, motor_rear_a, motor_rear_b,
   // corr_yaw, corr_pitch, corr_roll
   output logic [111:0]  rsp_tdata,
   input  logic          csr_wen,
   input  logic [2:0]    csr_index,
   input  logic [47:0]   csr_wdata
);

   localparam int CW = $clog2(RESULT_DEPTH + 1);
   localparam int LAT = apqm_pkg::LANE_LATENCY;

   apqm_pkg::gains_type   gains_ff [apqm_pkg::AXES];
   logic [14:0]           pid_limit_ff;
   apqm_pkg::mix_cfg_type mix_cfg_ff;

   logic                  req_fire, rsp_fire;
   logic [CW-1:0]         pending_ff, pending_in;
   logic [LAT-1:0]        vld_ff;
   logic [15:0]           thr_ff [LAT];
   logic signed [15:0]    corr [apqm_pkg::AXES];
   logic                  mix_valid;
   apqm_pkg::result_type  mix_result, rsp_result;

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign req_tready = pending_ff < CW'(RESULT_DEPTH);

   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + 1'b1;
      end else if (!req_fire && rsp_fire) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   // configuration and control
   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff[apqm_pkg::AXIS_YAW]   <= apqm_pkg::GAINS_YAW_RESET;
         gains_ff[apqm_pkg::AXIS_PITCH] <= apqm_pkg::GAINS_AXIS_RESET;
         gains_ff[apqm_pkg::AXIS_ROLL]  <= apqm_pkg::GAINS_AXIS_RESET;
         pid_limit_ff                   <= apqm_pkg::PID_LIMIT_RESET;
         mix_cfg_ff.throttle_cutoff     <= apqm_pkg::CUTOFF_RESET;
         mix_cfg_ff.motor_low           <= apqm_pkg::MOTOR_LOW_RESET;
         mix_cfg_ff.motor_high          <= apqm_pkg::MOTOR_HIGH_RESET;
         pending_ff                     <= '0;
         vld_ff                         <= '0;
      end else begin
         pending_ff <= pending_in;
         vld_ff     <= {vld_ff[LAT-2:0], req_fire};
         if (csr_wen) begin
            unique case (csr_index)
               apqm_pkg::CSR_GAINS_YAW: begin
                  gains_ff[apqm_pkg::AXIS_YAW] <= csr_wdata;
               end
               apqm_pkg::CSR_GAINS_PITCH: begin
                  gains_ff[apqm_pkg::AXIS_PITCH] <= csr_wdata;
               end
               apqm_pkg::CSR_GAINS_ROLL: begin
                  gains_ff[apqm_pkg::AXIS_ROLL] <= csr_wdata;
               end
               apqm_pkg::CSR_PID_LIMIT: begin
                  pid_limit_ff <= csr_wdata[14:0];
               end
               apqm_pkg::CSR_THROTTLE_CUTOFF: begin
                  mix_cfg_ff.throttle_cutoff <= csr_wdata[15:0];
               end
               apqm_pkg::CSR_MOTOR_LOW: begin
                  mix_cfg_ff.motor_low <= csr_wdata[15:0];
               end
               apqm_pkg::CSR_MOTOR_HIGH: begin
                  mix_cfg_ff.motor_high <= csr_wdata[15:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   // throttle rides alongside the lanes
   always_ff @(posedge clock) begin
      thr_ff[0] <= req_tdata[111:96];
      for (int i = 1; i < LAT; i++) begin
         thr_ff[i] <= thr_ff[i-1];
      end
   end

   for (genvar g = 0; g < apqm_pkg::AXES; g++) begin : g_lane
      apqm_lane #(
         .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (req_fire),
         .set_angle  (req_tdata[16*g +: 16]),
         .meas_angle (req_tdata[48 + 16*g +: 16]),
         .gains      (gains_ff[g]),
         .pid_limit  (pid_limit_ff),
         .corr       (corr[g])
      );
   end

   apqm_mixer u_mixer (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (vld_ff[LAT-1]),
      .throttle   (thr_ff[LAT-1]),
      .corr_yaw   (corr[apqm_pkg::AXIS_YAW]),
      .corr_pitch (corr[apqm_pkg::AXIS_PITCH]),
      .corr_roll  (corr[apqm_pkg::AXIS_ROLL]),
      .cfg        (mix_cfg_ff),
      .out_valid  (mix_valid),
      .result     (mix_result)
   );

   apqm_fifo #(
      .DEPTH (RESULT_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (mix_valid),
      .wr_data  (mix_result),
      .rd_valid (rsp_tvalid),
      .rd_ready (rsp_tready),
      .rd_data  (rsp_result)
   );

   assign rsp_tdata = rsp_result;

endmodule
